@@ design/pcg32b_pkg.sv @@
// ----------------------------------------------------------------------------
// pcg32b_pkg: shared types and constants of the PCG32 bounded generator.
// Holds the operation and status codes, the sequencer state type, the LCG
// multiplier and the XSH-RR output permutation.
// ----------------------------------------------------------------------------
`default_nettype none

package pcg32b_pkg;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_SEED  = 2'd0;
    localparam logic [1:0] OP_RAW   = 2'd1;
    localparam logic [1:0] OP_RANGE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Status codes carried in the output tuser.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_UNSEEDED = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    localparam logic [63:0] LCG_MULT    = 64'h5851_F42D_4C95_7F2D;
    localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
    localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];

    localparam int XSH_SHIFT_A = 18;
    localparam int XSH_SHIFT_B = 27;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_ADD,
        ST_MUL,
        ST_DIV_T,
        ST_DIV_R,
        ST_FIN,
        ST_DONE
    } t_state;

    // XSH-RR permutation of the old state: xorshift high, then rotate right
    // by the top five bits.
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] x;
        logic [31:0] xs;
        logic [4:0]  rot;
        x   = ((s >> XSH_SHIFT_A) ^ s) >> XSH_SHIFT_B;
        xs  = x[31:0];
        rot = s[63:59];
        return (xs >> rot) | (xs << (5'(5'd0 - rot)));
    endfunction

endpackage

`default_nettype wire

@@ design/pcg32_bounded_generator_top.sv @@
// ----------------------------------------------------------------------------
// pcg32_bounded_generator_top: PCG32 (XSH-RR) generator with range draws.
// One sequencer drives a shared 32x32 multiplier and a shared radix-2
// remainder unit to seed, draw raw words and draw bounded values.
// ----------------------------------------------------------------------------
// The block takes one item at a time on the input stream and returns exactly
// one result item for each. The op code in s_axis_tuser selects seeding, a raw
// 32-bit draw, a bounded draw in [low_bound, high_bound) or no operation. Each
// state advance is a 64-bit by 64-bit multiply (low half kept) built from
// three passes of a single 32x32 multiplier. A bounded draw first computes
// the rejection threshold (2^32 - span) mod span with a restoring remainder
// unit that retires one bit per cycle, then advances the state until a value
// at or above the threshold appears, then reduces it modulo span and adds
// low_bound. Draw requests before the first seed return status 1 and an empty
// range returns status 2, both without a state advance and with value zero.
// While an item is in progress s_axis_tready is low; the input opens again in
// the cycle after the result is loaded. A finished result sits in the output
// register until it is taken, and the next item can be accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg32_bounded_generator_top
    import pcg32b_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] seed_value, [95:64] low_bound, [127:96] high_bound
    input  wire logic [127:0] s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]   s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] value
    output logic [31:0]       m_axis_tdata,
    // [1:0] status
    output logic [1:0]        m_axis_tuser
);

    // Sequencer state.
    t_state r_fsm, n_fsm;

    // Generator state.
    logic [63:0] r_gen;
    logic [63:0] r_inc;
    logic [63:0] r_cnt;
    logic        r_seeded;

    // Item registers.
    logic [1:0]  r_op;
    logic [63:0] r_seed;
    logic [31:0] r_lo;
    logic [31:0] r_span;
    logic [31:0] r_thr;
    logic [31:0] r_draw;

    // Shared multiplier and accumulator.
    logic [1:0]  r_mcnt;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [63:0] w_addend;
    logic [63:0] w_acc_sum;

    // Shared remainder unit.
    logic [4:0]  r_dcnt;
    logic [31:0] r_dvd;
    logic [31:0] r_rem;
    logic [32:0] w_trial;
    logic        w_ge;
    logic [32:0] w_trial_sub;
    logic [31:0] w_rem_next;

    // Result staging and output register.
    logic [31:0] r_res_value;
    logic [1:0]  r_res_status;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic [1:0]  r_out_status;

    logic        w_accept;
    logic        w_load_out;
    logic        w_draw_ok;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_draw_ok = (r_draw >= r_thr);

    // Multiplier passes: lo*lo, lo*hi, hi*lo. The hi*hi term falls above bit
    // 63 and is never needed.
    always_comb begin
        unique case (r_mcnt)
            2'd0: begin
                w_mul_a = r_gen[31:0];
                w_mul_b = LCG_MULT_LO;
            end
            2'd1: begin
                w_mul_a = r_gen[31:0];
                w_mul_b = LCG_MULT_HI;
            end
            2'd2: begin
                w_mul_a = r_gen[63:32];
                w_mul_b = LCG_MULT_LO;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = 64'(w_mul_a) * 64'(w_mul_b);
    assign w_addend  = (r_mcnt == 2'd1) ? r_prod : {r_prod[31:0], 32'h0};
    assign w_acc_sum = r_acc + w_addend;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign w_trial     = {r_rem, r_dvd[31]};
    assign w_ge        = (w_trial >= {1'b0, r_span});
    assign w_trial_sub = w_trial - {1'b0, r_span};
    assign w_rem_next  = w_ge ? w_trial_sub[31:0] : w_trial[31:0];

    // Next-state logic.
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (s_axis_tuser == OP_SEED) begin
                        n_fsm = ST_SEED_ADD;
                    end else if (s_axis_tuser == OP_NONE || !r_seeded) begin
                        n_fsm = ST_DONE;
                    end else if (s_axis_tuser == OP_RAW) begin
                        n_fsm = ST_MUL;
                    end else if (s_axis_tdata[95:64] >= s_axis_tdata[127:96]) begin
                        n_fsm = ST_DONE;
                    end else begin
                        n_fsm = ST_DIV_T;
                    end
                end
            end
            ST_SEED_ADD: n_fsm = ST_MUL;
            ST_MUL: begin
                if (r_mcnt == 2'd3) begin
                    if (r_op != OP_RANGE) begin
                        n_fsm = ST_DONE;
                    end else if (w_draw_ok) begin
                        n_fsm = ST_DIV_R;
                    end else begin
                        n_fsm = ST_MUL;
                    end
                end
            end
            ST_DIV_T: if (r_dcnt == 5'd31) n_fsm = ST_MUL;
            ST_DIV_R: if (r_dcnt == 5'd31) n_fsm = ST_FIN;
            ST_FIN:   n_fsm = ST_DONE;
            ST_DONE:  if (!r_out_valid || m_axis_tready) n_fsm = ST_IDLE;
            default:  n_fsm = ST_IDLE;
        endcase
    end

    // Handshake outputs of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        unique case (r_fsm)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_DONE: w_load_out    = !r_out_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
                w_load_out    = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_gen       <= '0;
            r_inc       <= '0;
            r_cnt       <= '0;
            r_seeded    <= 1'b0;
            r_mcnt      <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (r_fsm == ST_IDLE) begin
                r_mcnt <= '0;
                r_dcnt <= '0;
                if (w_accept && s_axis_tuser == OP_SEED) begin
                    // Clearing the state and advancing once leaves the state
                    // equal to the new increment.
                    r_inc    <= {r_cnt[62:0], 1'b1};
                    r_seeded <= 1'b1;
                end
            end

            if (r_fsm == ST_SEED_ADD) begin
                r_gen <= r_inc + r_seed;
                r_cnt <= r_cnt + 64'd1;
            end

            if (r_fsm == ST_MUL) begin
                r_mcnt <= r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    r_gen <= w_acc_sum;
                end
            end

            if (r_fsm == ST_DIV_T || r_fsm == ST_DIV_R) begin
                r_dcnt <= r_dcnt + 5'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_fsm == ST_IDLE && w_accept) begin
            r_op         <= s_axis_tuser;
            r_seed       <= s_axis_tdata[63:0];
            r_lo         <= s_axis_tdata[95:64];
            r_span       <= s_axis_tdata[127:96] - s_axis_tdata[95:64];
            // Dividend for the threshold: 2^32 - span, wrapped to 32 bits.
            r_dvd        <= s_axis_tdata[95:64] - s_axis_tdata[127:96];
            r_rem        <= '0;
            r_res_value  <= '0;
            if (s_axis_tuser == OP_RAW || s_axis_tuser == OP_RANGE) begin
                if (!r_seeded) begin
                    r_res_status <= STAT_UNSEEDED;
                end else if (s_axis_tuser == OP_RANGE
                             && s_axis_tdata[95:64] >= s_axis_tdata[127:96]) begin
                    r_res_status <= STAT_EMPTY;
                end else begin
                    r_res_status <= STAT_OK;
                end
            end else begin
                r_res_status <= STAT_OK;
            end
        end

        if (r_fsm == ST_MUL) begin
            r_prod <= w_prod;
            if (r_mcnt == 2'd0) begin
                r_acc  <= r_inc;
                r_draw <= xsh_rr(r_gen);
            end else begin
                r_acc <= w_acc_sum;
            end
            if (r_mcnt == 2'd3) begin
                if (r_op == OP_RAW) begin
                    r_res_value <= r_draw;
                end
                // Accepted draw: load it as the dividend for the reduction.
                r_dvd <= r_draw;
                r_rem <= '0;
            end
        end

        if (r_fsm == ST_DIV_T || r_fsm == ST_DIV_R) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= w_rem_next;
            if (r_fsm == ST_DIV_T && r_dcnt == 5'd31) begin
                r_thr <= w_rem_next;
            end
        end

        if (r_fsm == ST_FIN) begin
            r_res_value <= r_lo + r_rem;
        end

        if (w_load_out) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    // A result with an error status carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> (m_axis_tdata == 32'h0))
        else $error("error result with nonzero value");

    // The partial remainder stays below the divisor during a reduction.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_fsm == ST_DIV_T || r_fsm == ST_DIV_R) && r_dcnt != 5'd0)
        |-> (r_rem < r_span))
        else $error("remainder not below span");

    // The stream counter steps by one on each seeding.
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_SEED_ADD) |=> (r_cnt == $past(r_cnt) + 64'd1))
        else $error("stream counter did not advance on seeding");

    // Once seeded, the stream increment is odd.
    a_inc_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seeded |-> r_inc[0])
        else $error("stream increment is even");

    // An accepted item closes the input until its result is loaded into the output register.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

endmodule

`default_nettype wire
